[hw/rtl/key_value_table_linear_match_defines.svh]
// Assertion macros for the key-value table.
`ifndef KEY_VALUE_TABLE_LINEAR_MATCH_DEFINES_SVH
`define KEY_VALUE_TABLE_LINEAR_MATCH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/kvt_pkg.sv]
// Shared types and codes for the key-value table.
package kvt_pkg;

    typedef enum logic [2:0] {
        OP_PUT      = 3'd0,
        OP_GET      = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_CONTAINS = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_NOMEM   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR
    } ctrl_state_t;

    // write address source
    typedef enum logic [1:0] {
        WSEL_SCAN,
        WSEL_TAIL,
        WSEL_SLOT
    } wsel_t;

    // read_value source for the result
    typedef enum logic [1:0] {
        VSEL_ZERO,
        VSEL_READ,
        VSEL_HOLD
    } vsel_t;

    typedef struct packed {
        logic    load;
        logic    step;
        logic    addr_last;
        logic    capture;
        logic    wr_en_key;
        logic    wr_en_val;
        wsel_t   wr_sel;
        logic    wr_move;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    respond;
        status_t rsp_status;
        logic    rsp_found;
        vsel_t   rsp_vsel;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic match;
        logic last;
        logic count_zero;
        logic count_full;
    } dp_status_t;

endpackage

[hw/rtl/kvt_datapath.sv]
// Datapath: key and value memories, entry count, scan pointer, result registers.
module kvt_datapath #(
    parameter int DEPTH      = 32,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [2:0]                   op,
    input  logic [KEY_BITS-1:0]          req_key,
    input  logic [VALUE_BITS-1:0]        req_value,
    input  kvt_pkg::cmd_t                cmd,
    output kvt_pkg::dp_status_t          stat,
    output logic                         done,
    output logic [1:0]                   status,
    output logic                         found,
    output logic [VALUE_BITS-1:0]        read_value,
    output logic [$clog2(DEPTH+1)-1:0]   entry_count
);
    import kvt_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [KEY_BITS-1:0]   key_mem [DEPTH];
    logic [VALUE_BITS-1:0] val_mem [DEPTH];

    op_t                   op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [IW-1:0]         addr_reg, addr_next;
    logic [IW-1:0]         idx_reg;
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic [IW-1:0]         slot_reg;
    logic [VALUE_BITS-1:0] hold_val_reg;
    logic                  done_reg;
    status_t               status_reg;
    logic                  found_reg;
    logic [VALUE_BITS-1:0] read_value_reg;

    logic [IW-1:0]         wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;
    logic [VALUE_BITS-1:0] rsp_val;

    always_comb
    begin
        addr_next = addr_reg;
        priority if (cmd.load)
            addr_next = '0;
        else if (cmd.addr_last)
            addr_next = IW'(count_reg - CW'(1));
        else if (cmd.step)
            addr_next = (addr_reg == IW'(DEPTH - 1)) ? '0 : addr_reg + IW'(1);
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (cmd.cnt_clr)
            count_next = '0;
        else if (cmd.cnt_inc)
            count_next = count_reg + CW'(1);
        else if (cmd.cnt_dec)
            count_next = count_reg - CW'(1);
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            WSEL_SCAN: wr_addr = idx_reg;
            WSEL_TAIL: wr_addr = IW'(count_reg);
            WSEL_SLOT: wr_addr = slot_reg;
            default:   wr_addr = idx_reg;
        endcase
        wr_key = cmd.wr_move ? rd_key_reg : key_reg;
        wr_val = cmd.wr_move ? rd_val_reg : val_reg;
    end

    always_comb
    begin
        unique case (cmd.rsp_vsel)
            VSEL_READ: rsp_val = rd_val_reg;
            VSEL_HOLD: rsp_val = hold_val_reg;
            default:   rsp_val = '0;
        endcase
    end

    // memories: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en_key)
            key_mem[wr_addr] <= wr_key;
        if (cmd.wr_en_val)
            val_mem[wr_addr] <= wr_val;
        rd_key_reg <= key_mem[addr_reg];
        rd_val_reg <= val_mem[addr_reg];
        idx_reg    <= addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(op);
            key_reg <= req_key;
            val_reg <= req_value;
        end
        if (cmd.capture)
        begin
            slot_reg     <= idx_reg;
            hold_val_reg <= rd_val_reg;
        end
        if (cmd.respond)
        begin
            status_reg     <= cmd.rsp_status;
            found_reg      <= cmd.rsp_found;
            read_value_reg <= rsp_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            addr_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            addr_reg  <= addr_next;
            done_reg  <= cmd.respond;
        end
    end

    assign stat.op         = op_reg;
    assign stat.match      = (rd_key_reg == key_reg);
    assign stat.last       = (CW'(idx_reg) == count_reg - CW'(1));
    assign stat.count_zero = (count_reg == '0);
    assign stat.count_full = (count_reg == CW'(DEPTH));

    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign entry_count = count_reg;

endmodule

[hw/rtl/kvt_ctrl.sv]
// Controller: sequences lookup scan, table update and result for each item.
module kvt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  kvt_pkg::dp_status_t  stat,
    output kvt_pkg::cmd_t        cmd,
    output logic                 busy
);
    import kvt_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // entry 0 is being read; move on to the scan unless decided here
                cmd.step   = 1'b1;
                state_next = S_SCAN;
                unique case (stat.op)
                    OP_CLEAR:
                    begin
                        cmd.cnt_clr = 1'b1;
                        cmd.respond = 1'b1;
                        state_next  = S_IDLE;
                    end
                    OP_GET, OP_REMOVE:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.respond    = 1'b1;
                            cmd.rsp_status = ST_EMPTY;
                            state_next     = S_IDLE;
                        end
                    end
                    OP_PUT:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.wr_en_key = 1'b1;
                            cmd.wr_en_val = 1'b1;
                            cmd.wr_sel    = WSEL_TAIL;
                            cmd.cnt_inc   = 1'b1;
                            cmd.respond   = 1'b1;
                            state_next    = S_IDLE;
                        end
                    end
                    OP_CONTAINS:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.respond = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    default:
                    begin
                        cmd.respond = 1'b1;
                        state_next  = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    state_next = S_IDLE;
                    unique case (stat.op)
                        OP_PUT:
                        begin
                            cmd.wr_en_val = 1'b1;
                            cmd.wr_sel    = WSEL_SCAN;
                            cmd.respond   = 1'b1;
                            cmd.rsp_found = 1'b1;
                        end
                        OP_GET:
                        begin
                            cmd.respond   = 1'b1;
                            cmd.rsp_found = 1'b1;
                            cmd.rsp_vsel  = VSEL_READ;
                        end
                        OP_REMOVE:
                        begin
                            cmd.capture   = 1'b1;
                            cmd.addr_last = 1'b1;
                            state_next    = S_MOVE_RD;
                        end
                        default:
                        begin
                            cmd.respond   = 1'b1;
                            cmd.rsp_found = 1'b1;
                        end
                    endcase
                end
                else if (stat.last)
                begin
                    state_next  = S_IDLE;
                    cmd.respond = 1'b1;
                    unique case (stat.op)
                        OP_PUT:
                        begin
                            if (stat.count_full)
                                cmd.rsp_status = ST_NOMEM;
                            else
                            begin
                                cmd.wr_en_key = 1'b1;
                                cmd.wr_en_val = 1'b1;
                                cmd.wr_sel    = WSEL_TAIL;
                                cmd.cnt_inc   = 1'b1;
                            end
                        end
                        OP_GET, OP_REMOVE:
                            cmd.rsp_status = ST_UNKNOWN;
                        default:
                            cmd.rsp_status = ST_OK;
                    endcase
                end
                else
                    cmd.step = 1'b1;
            end
            S_MOVE_RD:
                state_next = S_MOVE_WR;  // last entry being read
            S_MOVE_WR:
            begin
                cmd.wr_en_key = 1'b1;
                cmd.wr_en_val = 1'b1;
                cmd.wr_sel    = WSEL_SLOT;
                cmd.wr_move   = 1'b1;
                cmd.cnt_dec   = 1'b1;
                cmd.respond   = 1'b1;
                cmd.rsp_found = 1'b1;
                cmd.rsp_vsel  = VSEL_HOLD;
                state_next    = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

[hw/rtl/key_value_table_linear_match.sv]
// Key-value table of fixed capacity: user command port, controller and datapath.
//
// Key-value table holding up to DEPTH pairs as a dense list. Pulse start with
// op, req_key and req_value while busy is low; the result appears for one
// cycle with done high and must be taken then. Clear, unused op codes and
// any item on an empty table are decided in the check state without a scan.
// Other items scan the key memory one entry a cycle through its single read
// port until a hit or the last entry; a remove hit then reads the last entry
// and writes it into the freed slot. entry_count always shows the current
// count.
`include "key_value_table_linear_match_defines.svh"

module key_value_table_linear_match #(
    parameter int DEPTH      = 32,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  op,
    input  logic [KEY_BITS-1:0]         req_key,
    input  logic [VALUE_BITS-1:0]       req_value,
    output logic                        done,
    output logic [1:0]                  status,
    output logic                        found,
    output logic [VALUE_BITS-1:0]       read_value,
    output logic [$clog2(DEPTH+1)-1:0]  entry_count
);
    import kvt_pkg::*;

    localparam int CW = $clog2(DEPTH+1);

    cmd_t       cmd;
    dp_status_t stat;
    logic       rsp_empty;
    logic       rsp_nomem;
    logic       at_zero;
    logic       at_full;

    kvt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    kvt_datapath #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .req_key     (req_key),
        .req_value   (req_value),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .status      (status),
        .found       (found),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    assign rsp_empty = done && (status == ST_EMPTY);
    assign rsp_nomem = done && (status == ST_NOMEM);
    assign at_zero   = (entry_count == '0);
    assign at_full   = (entry_count == CW'(DEPTH));

    `KVT_ASSERT_NOW(a_done_not_busy, clk, rst_n, done, !busy, "result shown while busy")
    `KVT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done, "item not held busy")
    `KVT_ASSERT_NOW(a_empty_count, clk, rst_n, rsp_empty, at_zero && !found, "empty with entries")
    `KVT_ASSERT_NOW(a_nomem_full, clk, rst_n, rsp_nomem, at_full && !found, "no memory not full")

endmodule

[test/kvt_result_checker.sv]
// Result checker for the key-value table: table predictor and per-field comparison.
`timescale 1ns / 1ps

module kvt_result_checker #(
    parameter int DEPTH      = 32,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [2:0]                  op,
    input  logic [KEY_BITS-1:0]         req_key,
    input  logic [VALUE_BITS-1:0]       req_value,
    input  logic                        done,
    input  logic [1:0]                  status,
    input  logic                        found,
    input  logic [VALUE_BITS-1:0]       read_value,
    input  logic [$clog2(DEPTH+1)-1:0]  entry_count,
    output int                          mismatch_count,
    output int                          results_pending
);
    import kvt_pkg::*;

    localparam int CW = $clog2(DEPTH+1);

    typedef struct {
        status_t               status;
        logic                  found;
        logic [VALUE_BITS-1:0] value;
        logic [CW-1:0]         count;
    } table_result_t;

    logic [KEY_BITS-1:0]   table_keys   [DEPTH];
    logic [VALUE_BITS-1:0] table_values [DEPTH];
    int                    table_count;
    table_result_t         expected_results [$];
    int                    result_index;

    initial
    begin
        mismatch_count  = 0;
        results_pending = 0;
        table_count     = 0;
        result_index    = 0;
    end

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                 $realtime, result_index, field, got, want);
        mismatch_count++;
    endtask

    function automatic int find_slot(logic [KEY_BITS-1:0] key);
        for (int i = 0; i < table_count; i++)
            if (table_keys[i] == key)
                return i;
        return -1;
    endfunction

    // Applies one item to the table copy and returns the result it should give.
    function automatic table_result_t predict_result(logic [2:0] code,
                                                     logic [KEY_BITS-1:0] key,
                                                     logic [VALUE_BITS-1:0] value);
        table_result_t r;
        int            slot;
        r.status = ST_OK;
        r.found  = 1'b0;
        r.value  = '0;
        slot     = find_slot(key);
        case (code)
            OP_PUT:
            begin
                if (slot >= 0)
                begin
                    table_values[slot] = value;
                    r.found = 1'b1;
                end
                else if (table_count >= DEPTH)
                    r.status = ST_NOMEM;
                else
                begin
                    table_keys[table_count]   = key;
                    table_values[table_count] = value;
                    table_count++;
                end
            end
            OP_GET, OP_REMOVE:
            begin
                if (table_count == 0)
                    r.status = ST_EMPTY;
                else if (slot < 0)
                    r.status = ST_UNKNOWN;
                else
                begin
                    r.found = 1'b1;
                    r.value = table_values[slot];
                    if (code == OP_REMOVE)
                    begin
                        // last entry fills the hole
                        table_keys[slot]   = table_keys[table_count-1];
                        table_values[slot] = table_values[table_count-1];
                        table_count--;
                    end
                end
            end
            OP_CONTAINS:
                r.found = (slot >= 0);
            OP_CLEAR:
                table_count = 0;
            default:
                ;
        endcase
        r.count = CW'(table_count);
        return r;
    endfunction

    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("[%0t] result with no item outstanding", $realtime);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (found !== want.found)
                        report_mismatch("found", found, want.found);
                    if (read_value !== want.value)
                        report_mismatch("read_value", read_value, want.value);
                    if (entry_count !== want.count)
                        report_mismatch("entry_count", entry_count, want.count);
                end
                result_index++;
            end
            if (start && !busy)
                expected_results.push_back(predict_result(op, req_key, req_value));
            results_pending = expected_results.size();
        end
    end

endmodule

[test/tb_key_value_table_linear_match.sv]
// Testbench top for the key-value table: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps

module tb_key_value_table_linear_match;
    import kvt_pkg::*;

    localparam int DEPTH      = 32;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CW         = $clog2(DEPTH+1);
    localparam int POOL_SIZE  = 48;
    localparam int PHASES     = 12;
    localparam int PHASE_ITEMS = 100;

    // codes the block does not define; it must ignore them
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam logic [KEY_BITS-1:0]   KEY_MAX = '1;
    localparam logic [VALUE_BITS-1:0] VAL_MAX = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [2:0]            op;
    logic [KEY_BITS-1:0]   req_key;
    logic [VALUE_BITS-1:0] req_value;
    logic                  done;
    logic [1:0]            status;
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
    logic [CW-1:0]         entry_count;
    int                    mismatch_count;
    int                    results_pending;

    logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];
    bit                    gaps_on;

    key_value_table_linear_match #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .req_key     (req_key),
        .req_value   (req_value),
        .done        (done),
        .status      (status),
        .found       (found),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    kvt_result_checker #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .req_key         (req_key),
        .req_value       (req_value),
        .done            (done),
        .status          (status),
        .found           (found),
        .read_value      (read_value),
        .entry_count     (entry_count),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // Present one item at the falling edge and hold it until the block takes it.
    task automatic send_item(logic [2:0] code, logic [KEY_BITS-1:0] key,
                             logic [VALUE_BITS-1:0] value);
        @(negedge clk);
        start     <= 1'b1;
        op        <= code;
        req_key   <= key;
        req_value <= value;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start for a while; the payload carries noise meanwhile.
    task automatic idle_gap();
        int n;
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        repeat (n)
        begin
            @(negedge clk);
            start     <= 1'b0;
            op        <= 3'($urandom);
            req_key   <= $urandom;
            req_value <= $urandom;
        end
    endtask

    task automatic fill_key_pool();
        logic [KEY_BITS-1:0] base;
        base = $urandom;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (i < KEY_BITS / 2)
                key_pool[i] = base ^ (KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1));
            else
                key_pool[i] = $urandom;
        end
        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;
        key_pool[2] = base;
    endtask

    // put/get/remove/contains weights differ per phase to fill or drain the table
    task automatic random_item(int put_w, int get_w, int remove_w, int contains_w);
        int                  r;
        logic [2:0]          code;
        logic [KEY_BITS-1:0] key;
        r = $urandom_range(0, 99);
        if (r < put_w)
            code = OP_PUT;
        else if (r < put_w + get_w)
            code = OP_GET;
        else if (r < put_w + get_w + remove_w)
            code = OP_REMOVE;
        else if (r < put_w + get_w + remove_w + contains_w)
            code = OP_CONTAINS;
        else if (r < 97)
            code = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else
            code = OP_CLEAR;
        if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            key = $urandom;
        send_item(code, key, $urandom);
        idle_gap();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        op        = OP_PUT;
        req_key   = '0;
        req_value = '0;
        gaps_on   = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, update, hit/miss, remove at slot 0, unused codes, clear
        send_item(OP_GET,      '0,           '0);
        send_item(OP_REMOVE,   KEY_MAX,      VAL_MAX);
        send_item(OP_CONTAINS, KEY_MAX,      '0);
        send_item(OP_PUT,      '0,           VAL_MAX);
        idle_gap();
        send_item(OP_PUT,      KEY_MAX,      '0);
        send_item(OP_PUT,      '0,           32'h1234_5678);
        send_item(OP_GET,      '0,           VAL_MAX);
        send_item(OP_GET,      KEY_MAX,      '0);
        send_item(OP_GET,      32'h0000_0001, '0);
        send_item(OP_CONTAINS, 32'h8000_0000, '0);
        send_item(OP_CONTAINS, KEY_MAX,      '0);
        send_item(OP_REMOVE,   32'h7FFF_FFFF, '0);
        send_item(OP_PUT,      32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_item(OP_REMOVE,   '0,           '0);
        send_item(OP_GET,      32'hA5A5_A5A5, '0);
        send_item(OP_REMOVE,   32'hA5A5_A5A5, '0);
        send_item(OP_SPARE_LO, KEY_MAX,      VAL_MAX);
        send_item(OP_SPARE_LO + 3'd1, '0,    '0);
        send_item(OP_SPARE_HI, KEY_MAX,      VAL_MAX);
        send_item(OP_CLEAR,    KEY_MAX,      VAL_MAX);
        send_item(OP_GET,      KEY_MAX,      '0);
        send_item(OP_PUT,      32'h0F0F_0F0F, 32'hF0F0_F0F0);
        idle_gap();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            fill_key_pool();
            gaps_on = (ph % 4 != 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                case (ph % 3)
                    0:       random_item(70, 10, 5, 10);
                    1:       random_item(35, 20, 20, 17);
                    default: random_item(15, 15, 50, 12);
                endcase
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (results_pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
